### design/pwg_pkg.sv
// Shared types, constants and the quarter-wave table for the periodic waveform generator.
// No dependencies; every other design file imports this package.
package pwg_pkg;

    localparam int PERIOD_W   = 16;
    localparam int TIME_W     = 32;
    localparam int LEVEL_W    = 8;
    localparam int NUM_W      = PERIOD_W + LEVEL_W;  // scaled phase, below 256 * divisor
    localparam int MOD_STAGES = TIME_W;              // one remainder bit per stage
    localparam int DIV_STAGES = LEVEL_W;             // one quotient bit per stage
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);
    localparam int QTAB_LEN   = 20;
    localparam int QIDX_W     = $clog2(QTAB_LEN);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);
    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = PERIOD_W'(2);
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX    = LEVEL_W'(255);

    // sine quadrant boundaries on the 0..79 phase index
    localparam logic [LEVEL_W-1:0] Q1_END = LEVEL_W'(QTAB_LEN);
    localparam logic [LEVEL_W-1:0] Q2_END = LEVEL_W'(2 * QTAB_LEN);
    localparam logic [LEVEL_W-1:0] Q3_END = LEVEL_W'(3 * QTAB_LEN);
    localparam logic [LEVEL_W-1:0] Q4_END = LEVEL_W'(4 * QTAB_LEN);

    localparam logic [1:0] MODE_SINE = 2'd0;
    localparam logic [1:0] MODE_SAW  = 2'd1;
    localparam logic [1:0] MODE_TRI  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    typedef enum logic [1:0] {
        WAVE_SINE,
        WAVE_SAW,
        WAVE_TRI,
        WAVE_NONE
    } t_wave;

    typedef struct packed {
        logic [TIME_W-1:0] time_us;
        t_wave             wave;
    } t_item;

    function automatic logic [LEVEL_W-1:0] qwave(input logic [QIDX_W-1:0] idx);
        logic [LEVEL_W-1:0] v;
        unique case (idx)
            5'd0:    v = 8'd127;
            5'd1:    v = 8'd137;
            5'd2:    v = 8'd147;
            5'd3:    v = 8'd157;
            5'd4:    v = 8'd167;
            5'd5:    v = 8'd176;
            5'd6:    v = 8'd185;
            5'd7:    v = 8'd194;
            5'd8:    v = 8'd202;
            5'd9:    v = 8'd210;
            5'd10:   v = 8'd218;
            5'd11:   v = 8'd224;
            5'd12:   v = 8'd231;
            5'd13:   v = 8'd236;
            5'd14:   v = 8'd241;
            5'd15:   v = 8'd245;
            5'd16:   v = 8'd249;
            5'd17:   v = 8'd251;
            5'd18:   v = 8'd253;
            5'd19:   v = 8'd255;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

### design/pwg_front.sv
// Front end: period register, input transaction acceptance and mode decode.
// Depends on pwg_pkg; feeds pwg_queue.
module pwg_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pwg_pkg::PERIOD_W-1:0]   i_period,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [pwg_pkg::TIME_W-1:0]     i_time_us,
    input  logic [1:0]                     i_mode,
    input  logic                           i_q_full,
    output logic                           o_push,
    output pwg_pkg::t_item                 o_item,
    output logic [pwg_pkg::PERIOD_W-1:0]   o_period
);
    import pwg_pkg::*;

    logic [PERIOD_W-1:0] r_period;
    logic [PERIOD_W-1:0] n_period;
    t_wave               w_wave;

    assign o_cfg_ready = 1'b1;
    assign n_period    = (i_period < PERIOD_MIN) ? PERIOD_MIN : i_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_period <= n_period;
        end
    end

    always_comb begin
        unique case (i_mode)
            MODE_SINE: w_wave = WAVE_SINE;
            MODE_SAW:  w_wave = WAVE_SAW;
            MODE_TRI:  w_wave = WAVE_TRI;
            MODE_NONE: w_wave = WAVE_NONE;
            default:   w_wave = WAVE_NONE;
        endcase
    end

    assign o_in_stall     = i_q_full;
    assign o_push         = i_in_valid && !i_q_full;
    assign o_item.time_us = i_time_us;
    assign o_item.wave    = w_wave;
    assign o_period       = r_period;

endmodule

### design/pwg_queue.sv
// Short FIFO decoupling the front end from the arithmetic back end.
// Depends on pwg_pkg (t_item, QDEPTH).
module pwg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pwg_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output pwg_pkg::t_item o_item
);
    import pwg_pkg::*;

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QAW:0]   r_count;
    logic           w_pop;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QAW'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == QAW'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/pwg_back.sv
// Back end: phase remainder pipeline, triangle fold and scale, quotient pipeline,
// level lookup and output register. Depends on pwg_pkg.
module pwg_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pwg_pkg::PERIOD_W-1:0]  i_period,
    input  logic                          i_valid,
    input  pwg_pkg::t_item                i_item,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pwg_pkg::LEVEL_W-1:0]   o_level
);
    import pwg_pkg::*;

    logic                w_adv;
    logic [PERIOD_W-1:0] w_half;

    // remainder stages: t = time_us mod period
    logic                r_mvld  [MOD_STAGES];
    logic [PERIOD_W-1:0] r_mrem  [MOD_STAGES];
    logic [TIME_W-1:0]   r_mtim  [MOD_STAGES];
    t_wave               r_mwave [MOD_STAGES];
    logic [PERIOD_W-1:0] n_mrem  [MOD_STAGES];

    // triangle fold, then scale to numerator
    logic                r_p1vld;
    logic [PERIOD_W-1:0] r_p1base;
    t_wave               r_p1wave;
    logic                r_p1fall;
    logic                n_p1fall;
    logic                r_p2vld;
    logic [NUM_W-1:0]    r_p2num;
    logic [NUM_W-1:0]    n_p2num;
    t_wave               r_p2wave;
    logic                r_p2fall;

    // quotient stages: level index = numerator / divisor
    logic                r_dvld  [DIV_STAGES];
    logic [PERIOD_W-1:0] r_drem  [DIV_STAGES];
    logic [LEVEL_W-1:0]  r_dlo   [DIV_STAGES];
    t_wave               r_dwave [DIV_STAGES];
    logic                r_dfall [DIV_STAGES];
    logic [PERIOD_W-1:0] n_drem  [DIV_STAGES];
    logic [LEVEL_W-1:0]  n_dlo   [DIV_STAGES];

    logic                r_ovld;
    logic [LEVEL_W-1:0]  r_olevel;
    logic [LEVEL_W-1:0]  n_olevel;
    logic [PERIOD_W-1:0] w_lastden;

    assign w_adv  = !r_ovld || !i_out_stall;
    assign o_pop  = w_adv && i_valid;
    assign w_half = {1'b0, i_period[PERIOD_W-1:1]};

    always_comb begin
        logic [PERIOD_W-1:0] v_rin;
        logic [TIME_W-1:0]   v_tin;
        logic [PERIOD_W:0]   v_trial;
        for (int k = 0; k < MOD_STAGES; k++) begin
            if (k == 0) begin
                v_rin = '0;
                v_tin = i_item.time_us;
            end else begin
                v_rin = r_mrem[k-1];
                v_tin = r_mtim[k-1];
            end
            v_trial = {v_rin, v_tin[TIME_W-1]};
            if (v_trial >= {1'b0, i_period}) begin
                n_mrem[k] = PERIOD_W'(v_trial - {1'b0, i_period});
            end else begin
                n_mrem[k] = v_trial[PERIOD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < MOD_STAGES; k++) begin
                r_mrem[k] <= n_mrem[k];
                if (k == 0) begin
                    r_mtim[k]  <= {i_item.time_us[TIME_W-2:0], 1'b0};
                    r_mwave[k] <= i_item.wave;
                end else begin
                    r_mtim[k]  <= {r_mtim[k-1][TIME_W-2:0], 1'b0};
                    r_mwave[k] <= r_mwave[k-1];
                end
            end
        end
    end

    // falling half of the triangle works on t - half
    assign n_p1fall = (r_mwave[MOD_STAGES-1] == WAVE_TRI) && (r_mrem[MOD_STAGES-1] >= w_half);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1fall <= n_p1fall;
            r_p1wave <= r_mwave[MOD_STAGES-1];
            r_p1base <= n_p1fall ? r_mrem[MOD_STAGES-1] - w_half : r_mrem[MOD_STAGES-1];
        end
    end

    // sine scales by 80, the others by 255
    always_comb begin
        if (r_p1wave == WAVE_SINE) begin
            n_p2num = NUM_W'({r_p1base, 6'b0}) + NUM_W'({r_p1base, 4'b0});
        end else begin
            n_p2num = {r_p1base, 8'b0} - NUM_W'(r_p1base);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p2num  <= n_p2num;
            r_p2wave <= r_p1wave;
            r_p2fall <= r_p1fall;
        end
    end

    // numerator < 256 * divisor, so the upper part starts as a valid remainder
    always_comb begin
        logic [PERIOD_W-1:0] v_rin;
        logic [LEVEL_W-1:0]  v_lo;
        t_wave               v_wave;
        logic [PERIOD_W-1:0] v_den;
        logic [PERIOD_W:0]   v_trial;
        logic                v_ge;
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (j == 0) begin
                v_rin  = r_p2num[NUM_W-1:LEVEL_W];
                v_lo   = r_p2num[LEVEL_W-1:0];
                v_wave = r_p2wave;
            end else begin
                v_rin  = r_drem[j-1];
                v_lo   = r_dlo[j-1];
                v_wave = r_dwave[j-1];
            end
            v_den   = (v_wave == WAVE_TRI) ? w_half : i_period;
            v_trial = {v_rin, v_lo[LEVEL_W-1]};
            v_ge    = (v_trial >= {1'b0, v_den});
            n_drem[j] = v_ge ? PERIOD_W'(v_trial - {1'b0, v_den}) : v_trial[PERIOD_W-1:0];
            n_dlo[j]  = {v_lo[LEVEL_W-2:0], v_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int j = 0; j < DIV_STAGES; j++) begin
                r_drem[j] <= n_drem[j];
                r_dlo[j]  <= n_dlo[j];
                if (j == 0) begin
                    r_dwave[j] <= r_p2wave;
                    r_dfall[j] <= r_p2fall;
                end else begin
                    r_dwave[j] <= r_dwave[j-1];
                    r_dfall[j] <= r_dfall[j-1];
                end
            end
        end
    end

    always_comb begin
        logic [LEVEL_W-1:0] v_q;
        logic [LEVEL_W-1:0] v_sine;
        v_q = r_dlo[DIV_STAGES-1];
        priority if (v_q < Q1_END) begin
            v_sine = qwave(QIDX_W'(v_q));
        end else if (v_q < Q2_END) begin
            v_sine = qwave(QIDX_W'(Q2_END - 1'b1 - v_q));
        end else if (v_q < Q3_END) begin
            v_sine = LEVEL_MAX - qwave(QIDX_W'(v_q - Q2_END));
        end else begin
            v_sine = LEVEL_MAX - qwave(QIDX_W'(Q4_END - 1'b1 - v_q));
        end
        unique case (r_dwave[DIV_STAGES-1])
            WAVE_SINE: n_olevel = v_sine;
            WAVE_SAW:  n_olevel = v_q;
            WAVE_TRI:  n_olevel = r_dfall[DIV_STAGES-1] ? LEVEL_MAX - v_q : v_q;
            WAVE_NONE: n_olevel = '0;
            default:   n_olevel = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_olevel <= n_olevel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MOD_STAGES; k++) begin
                r_mvld[k] <= 1'b0;
            end
            for (int j = 0; j < DIV_STAGES; j++) begin
                r_dvld[j] <= 1'b0;
            end
            r_p1vld <= 1'b0;
            r_p2vld <= 1'b0;
            r_ovld  <= 1'b0;
        end else if (w_adv) begin
            r_mvld[0] <= i_valid;
            for (int k = 1; k < MOD_STAGES; k++) begin
                r_mvld[k] <= r_mvld[k-1];
            end
            r_p1vld   <= r_mvld[MOD_STAGES-1];
            r_p2vld   <= r_p1vld;
            r_dvld[0] <= r_p2vld;
            for (int j = 1; j < DIV_STAGES; j++) begin
                r_dvld[j] <= r_dvld[j-1];
            end
            r_ovld <= r_dvld[DIV_STAGES-1];
        end
    end

    assign o_out_valid = r_ovld;
    assign o_level     = r_olevel;

    assign w_lastden = (r_dwave[DIV_STAGES-1] == WAVE_TRI) ? w_half : i_period;

    a_phase_below_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mvld[MOD_STAGES-1] |-> (r_mrem[MOD_STAGES-1] < i_period))
        else $error("phase remainder not below period");

    a_fold_within_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1vld && r_p1fall) |-> (r_p1base <= w_half))
        else $error("triangle fold exceeds half period");

    a_quot_rem_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dvld[DIV_STAGES-1] |-> (r_drem[DIV_STAGES-1] < w_lastden))
        else $error("quotient remainder not below divisor");

    a_sine_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dvld[DIV_STAGES-1] && r_dwave[DIV_STAGES-1] == WAVE_SINE)
            |-> (r_dlo[DIV_STAGES-1] < Q4_END))
        else $error("sine index out of range");

endmodule

### design/periodic_waveform_generator.sv
// Top level of the periodic waveform generator: front end, queue and back end.
// Depends on pwg_pkg, pwg_front, pwg_queue and pwg_back.

// Takes one timestamp transaction per clock while o_in_stall is low and returns one 8-bit
// level per transaction, in order, for phase t = time_us mod period: quarter-wave table
// sine, sawtooth or triangle (mode 3 gives 0). Each transaction passes through the
// 32-stage bit-per-stage remainder pipeline, two fold/scale stages, the 8-stage quotient
// pipeline and the output register. A four-entry queue after the input lets the front
// keep taking transactions while the output is stalled; the whole back-end pipeline holds
// while a result waits. Period writes below 2 saturate to 2 and must only be made while
// no transaction is in flight.
module periodic_waveform_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pwg_pkg::PERIOD_W-1:0]  i_period,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pwg_pkg::TIME_W-1:0]    i_time_us,
    input  logic [1:0]                    i_mode,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pwg_pkg::LEVEL_W-1:0]   o_level
);
    import pwg_pkg::*;

    logic                w_push;
    t_item               w_fitem;
    logic                w_full;
    logic                w_pop;
    logic                w_qvalid;
    t_item               w_qitem;
    logic [PERIOD_W-1:0] w_period;

    pwg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_period    (i_period),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_time_us   (i_time_us),
        .i_mode      (i_mode),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_item      (w_fitem),
        .o_period    (w_period)
    );

    pwg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_item  (w_qitem)
    );

    pwg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_period    (w_period),
        .i_valid     (w_qvalid),
        .i_item      (w_qitem),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_level     (o_level)
    );

endmodule
